/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the curve evaluator checks, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge out of reset
`define PWL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwl implication check failed");

// Invariant checked at every clock edge out of reset
`define PWL_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pwl invariant check failed");

`endif

/* sv/pwl_pkg.sv */
// ----------------------------------------------------------------------------
// pwl_pkg
// Shared types and constants of the piecewise-linear curve evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pwl_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 11;
    localparam int VAL_W       = 16;
    localparam int PROD_W      = 2 * VAL_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;
    localparam int DIV_CNT_W   = 5;

    // Opcode of an input word
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Classified word passed from front to back
    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] x;
        logic [VAL_W-1:0] y;
        logic [IDX_W-1:0] len_m1;
        logic             len_zero;
    } pwl_word_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } pwl_q_status_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PROBE_RD,
        BK_PROBE_CMP,
        BK_TAIL_RD,
        BK_TAIL_CMP,
        BK_MUL,
        BK_DIV
    } pwl_state_t;

endpackage

`default_nettype wire

/* sv/piecewise_linear_curve_eval_top.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_curve_eval_top
// Piecewise-linear curve evaluator over a table of up to 1024 Q0.16 points.
// ----------------------------------------------------------------------------
// A word is taken at a clock edge with start high and busy low; busy rises
// only when the two-word queue between the front and the back is full. A
// write word (opcode 0) stores one point and gives no result; the back
// stores it as it pops the word in its idle state. An evaluate word
// (opcode 1) gives one result on y_out, not_found and segment, shown for
// exactly one cycle with done high; the receiver cannot stall it, so it
// must be captured in that cycle. An evaluate leaves the queue in the idle
// state; each binary-search probe (at most 11 probes for 1024 points) then
// reads both segment ends from the x/y tables and compares them. When the
// search misses, the last point is read and tested; when it interpolates,
// a multiply step is followed by the bit-serial divider. With an empty
// table the result comes from the idle state with no search. Write
// cfg_wdata (the point count) with cfg_we only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_curve_eval_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          opcode,
    input  wire logic [pwl_pkg::IDX_W-1:0]     point_index,
    input  wire logic [pwl_pkg::VAL_W-1:0]     x_value,
    input  wire logic [pwl_pkg::VAL_W-1:0]     y_value,
    input  wire logic                          cfg_we,
    input  wire logic [pwl_pkg::CNT_W-1:0]     cfg_wdata,
    output logic                               done,
    output logic [pwl_pkg::VAL_W-1:0]          y_out,
    output logic                               not_found,
    output logic [pwl_pkg::IDX_W-1:0]          segment
);

    pwl_pkg::pwl_word_t        push_word;
    pwl_pkg::pwl_word_t        head;
    pwl_pkg::pwl_q_status_t    q_status;
    logic                      push;
    logic                      pop;

    pwl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .opcode      (opcode),
        .point_index (point_index),
        .x_value     (x_value),
        .y_value     (y_value),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .q_status    (q_status),
        .busy        (busy),
        .push        (push),
        .push_word   (push_word)
    );

    pwl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    pwl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .done      (done),
        .y_out     (y_out),
        .not_found (not_found),
        .segment   (segment)
    );

endmodule

`default_nettype wire

/* sv/pwl_queue.sv */
// ----------------------------------------------------------------------------
// pwl_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pwl_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire pwl_pkg::pwl_word_t    push_word,
    input  wire logic                  pop,
    output pwl_pkg::pwl_word_t         head,
    output pwl_pkg::pwl_q_status_t     status
);

    pwl_pkg::pwl_word_t                 entry_reg [pwl_pkg::QUEUE_DEPTH];
    logic [pwl_pkg::QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [pwl_pkg::QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [pwl_pkg::QCNT_W-1:0]         count_reg, count_next;
    logic                               do_push;
    logic                               do_pop;

    assign status.full  = (count_reg == pwl_pkg::QCNT_W'(pwl_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = entry_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

/* sv/pwl_div.sv */
// ----------------------------------------------------------------------------
// pwl_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the upper half of the dividend is below the divisor, so the quotient fits
// in VAL_W bits and VAL_W steps suffice.
// ----------------------------------------------------------------------------
`default_nettype none

module pwl_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [pwl_pkg::PROD_W-1:0]    num,
    input  wire logic [pwl_pkg::VAL_W-1:0]     den,
    output logic                               done,
    output logic [pwl_pkg::VAL_W-1:0]          quot
);

    logic [pwl_pkg::VAL_W-1:0]      rem_reg, rem_next;
    logic [pwl_pkg::VAL_W-1:0]      low_reg, low_next;
    logic [pwl_pkg::VAL_W-1:0]      den_reg, den_next;
    logic [pwl_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic [pwl_pkg::VAL_W:0]        trial;
    logic                           fits;

    assign trial = {rem_reg, low_reg[pwl_pkg::VAL_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    // Load, then shift in one dividend bit per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = num[pwl_pkg::PROD_W-1:pwl_pkg::VAL_W];
            low_next = num[pwl_pkg::VAL_W-1:0];
            den_next = den;
            cnt_next = pwl_pkg::DIV_CNT_W'(pwl_pkg::VAL_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? pwl_pkg::VAL_W'(trial - {1'b0, den_reg})
                             : trial[pwl_pkg::VAL_W-1:0];
            low_next  = {low_reg[pwl_pkg::VAL_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == pwl_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = low_reg;

endmodule

`default_nettype wire

/* sv/pwl_front.sv */
// ----------------------------------------------------------------------------
// pwl_front
// Accepts input words, holds the point count register and classifies each
// word with the saturated table length before queueing it.
// ----------------------------------------------------------------------------
`default_nettype none

module pwl_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic                         opcode,
    input  wire logic [pwl_pkg::IDX_W-1:0]    point_index,
    input  wire logic [pwl_pkg::VAL_W-1:0]    x_value,
    input  wire logic [pwl_pkg::VAL_W-1:0]    y_value,
    input  wire logic                         cfg_we,
    input  wire logic [pwl_pkg::CNT_W-1:0]    cfg_wdata,
    input  wire pwl_pkg::pwl_q_status_t       q_status,
    output logic                              busy,
    output logic                              push,
    output pwl_pkg::pwl_word_t                push_word
);

    logic [pwl_pkg::CNT_W-1:0] point_count_reg, point_count_next;
    logic [pwl_pkg::CNT_W-1:0] len_sat;
    logic [pwl_pkg::CNT_W-1:0] len_m1_full;

    // Capture the count register
    always_comb
    begin
        point_count_next = point_count_reg;
        if (cfg_we)
        begin
            point_count_next = cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= pwl_pkg::CNT_W'(1);
        end
        else
        begin
            point_count_reg <= point_count_next;
        end
    end

    // Saturate the length to the table depth
    assign len_sat = (point_count_reg > pwl_pkg::CNT_W'(pwl_pkg::MAX_POINTS))
                   ? pwl_pkg::CNT_W'(pwl_pkg::MAX_POINTS) : point_count_reg;
    assign len_m1_full = len_sat - 1'b1;

    assign busy = q_status.full;
    assign push = start && !q_status.full;

    // Classify the word
    always_comb
    begin
        push_word.op       = opcode;
        push_word.idx      = point_index;
        push_word.x        = x_value;
        push_word.y        = y_value;
        push_word.len_m1   = len_m1_full[pwl_pkg::IDX_W-1:0];
        push_word.len_zero = (len_sat == '0);
    end

endmodule

`default_nettype wire

/* sv/pwl_back.sv */
// ----------------------------------------------------------------------------
// pwl_back
// Executes queued words: writes curve points into the x/y tables, or runs
// the binary search, the multiply and the serial divide of an evaluation.
// ----------------------------------------------------------------------------
`default_nettype none

module pwl_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pwl_pkg::pwl_word_t            head,
    input  wire pwl_pkg::pwl_q_status_t        q_status,
    output logic                               pop,
    output logic                               done,
    output logic [pwl_pkg::VAL_W-1:0]          y_out,
    output logic                               not_found,
    output logic [pwl_pkg::IDX_W-1:0]          segment
);

    pwl_pkg::pwl_state_t            state_reg, state_next;

    // Point tables
    logic [pwl_pkg::VAL_W-1:0]      x_mem [pwl_pkg::MAX_POINTS];
    logic [pwl_pkg::VAL_W-1:0]      y_mem [pwl_pkg::MAX_POINTS];
    logic [pwl_pkg::VAL_W-1:0]      xa_rd_reg, xb_rd_reg, ya_rd_reg, yb_rd_reg;
    logic [pwl_pkg::IDX_W-1:0]      addr_a, addr_b;
    logic                           mem_we;

    // Search and interpolation state
    logic [pwl_pkg::CNT_W-1:0]      lo_reg, lo_next;
    logic [pwl_pkg::CNT_W-1:0]      hi_reg, hi_next;
    logic [pwl_pkg::IDX_W-1:0]      len_m1_reg, len_m1_next;
    logic [pwl_pkg::VAL_W-1:0]      xq_reg, xq_next;
    logic [pwl_pkg::VAL_W-1:0]      dx_reg, dx_next;
    logic [pwl_pkg::VAL_W-1:0]      dxq_reg, dxq_next;
    logic [pwl_pkg::VAL_W-1:0]      dy_reg, dy_next;
    logic [pwl_pkg::VAL_W-1:0]      base_y_reg, base_y_next;
    logic                           dec_reg, dec_next;
    logic [pwl_pkg::IDX_W-1:0]      seg_reg, seg_next;

    // Result registers
    logic                           done_reg, done_next;
    logic [pwl_pkg::VAL_W-1:0]      y_out_reg, y_out_next;
    logic                           nf_reg, nf_next;
    logic [pwl_pkg::IDX_W-1:0]      seg_out_reg, seg_out_next;

    // Combinational helpers
    logic [pwl_pkg::CNT_W:0]        pivot_sum;
    logic [pwl_pkg::IDX_W-1:0]      pivot;
    logic [pwl_pkg::VAL_W-1:0]      probe_start;
    logic                           hit;
    logic                           go_right;
    logic [pwl_pkg::CNT_W-1:0]      lo_step, hi_step;
    logic                           more;
    logic                           flat;
    logic                           eval_pop;
    logic                           div_start;
    logic                           div_done;
    logic [pwl_pkg::VAL_W-1:0]      div_quot;
    logic [pwl_pkg::PROD_W-1:0]     product;
    logic [pwl_pkg::VAL_W+1:0]      interp_sum;
    logic [pwl_pkg::VAL_W-1:0]      interp_y;

    // Probe at the midpoint; hi is kept one past the right bound
    assign pivot_sum   = {1'b0, lo_reg} + {1'b0, hi_reg} - 1'b1;
    assign pivot       = pivot_sum[pwl_pkg::IDX_W:1];
    assign probe_start = (pivot == '0) ? '0 : xa_rd_reg;
    assign hit         = (probe_start <= xq_reg) && (xq_reg <= xb_rd_reg);
    assign go_right    = (xb_rd_reg < xq_reg);
    assign lo_step     = go_right ? ({1'b0, pivot} + 1'b1) : lo_reg;
    assign hi_step     = go_right ? hi_reg : {1'b0, pivot};
    assign more        = (lo_step < hi_step);
    assign flat        = (xb_rd_reg <= xa_rd_reg);

    assign eval_pop = (state_reg == pwl_pkg::BK_IDLE) && !q_status.empty
                   && (head.op == pwl_pkg::OP_EVAL);

    // Read both ends of the probed segment, or the last point
    assign addr_a = pivot - 1'b1;
    assign addr_b = (state_reg == pwl_pkg::BK_TAIL_RD) ? len_m1_reg : pivot;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            x_mem[head.idx] <= head.x;
            y_mem[head.idx] <= head.y;
        end
        xa_rd_reg <= x_mem[addr_a];
        xb_rd_reg <= x_mem[addr_b];
        ya_rd_reg <= y_mem[addr_a];
        yb_rd_reg <= y_mem[addr_b];
    end

    // Scale the span; the divider registers the product
    assign product = dxq_reg * dy_reg;

    pwl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (product),
        .den   (dx_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Apply the quotient to the start y and clamp to 0..1.0
    always_comb
    begin
        if (dec_reg)
        begin
            interp_sum = {2'b00, base_y_reg} - {2'b00, div_quot};
        end
        else
        begin
            interp_sum = {2'b00, base_y_reg} + {2'b00, div_quot};
        end
        if (interp_sum[pwl_pkg::VAL_W+1])
        begin
            interp_y = '0;
        end
        else if (interp_sum[pwl_pkg::VAL_W])
        begin
            interp_y = '1;
        end
        else
        begin
            interp_y = interp_sum[pwl_pkg::VAL_W-1:0];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pwl_pkg::BK_IDLE:
            begin
                if (eval_pop && !head.len_zero)
                begin
                    state_next = pwl_pkg::BK_PROBE_RD;
                end
            end
            pwl_pkg::BK_PROBE_RD:
            begin
                state_next = pwl_pkg::BK_PROBE_CMP;
            end
            pwl_pkg::BK_PROBE_CMP:
            begin
                if (hit)
                begin
                    if ((pivot == '0) || flat)
                    begin
                        state_next = pwl_pkg::BK_IDLE;
                    end
                    else
                    begin
                        state_next = pwl_pkg::BK_MUL;
                    end
                end
                else if (more)
                begin
                    state_next = pwl_pkg::BK_PROBE_RD;
                end
                else
                begin
                    state_next = pwl_pkg::BK_TAIL_RD;
                end
            end
            pwl_pkg::BK_TAIL_RD:
            begin
                state_next = pwl_pkg::BK_TAIL_CMP;
            end
            pwl_pkg::BK_TAIL_CMP:
            begin
                state_next = pwl_pkg::BK_IDLE;
            end
            pwl_pkg::BK_MUL:
            begin
                state_next = pwl_pkg::BK_DIV;
            end
            pwl_pkg::BK_DIV:
            begin
                if (div_done)
                begin
                    state_next = pwl_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = pwl_pkg::BK_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        pop          = 1'b0;
        mem_we       = 1'b0;
        div_start    = 1'b0;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        len_m1_next  = len_m1_reg;
        xq_next      = xq_reg;
        dx_next      = dx_reg;
        dxq_next     = dxq_reg;
        dy_next      = dy_reg;
        base_y_next  = base_y_reg;
        dec_next     = dec_reg;
        seg_next     = seg_reg;
        done_next    = 1'b0;
        y_out_next   = y_out_reg;
        nf_next      = nf_reg;
        seg_out_next = seg_out_reg;
        case (state_reg)
            pwl_pkg::BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop = 1'b1;
                    if (head.op == pwl_pkg::OP_WRITE)
                    begin
                        mem_we = 1'b1;
                    end
                    else if (head.len_zero)
                    begin
                        done_next    = 1'b1;
                        y_out_next   = '0;
                        nf_next      = 1'b1;
                        seg_out_next = '0;
                    end
                    else
                    begin
                        lo_next     = '0;
                        hi_next     = {1'b0, head.len_m1} + 1'b1;
                        len_m1_next = head.len_m1;
                        xq_next     = head.x;
                    end
                end
            end
            pwl_pkg::BK_PROBE_CMP:
            begin
                if (hit)
                begin
                    if (pivot == '0)
                    begin
                        done_next    = 1'b1;
                        y_out_next   = yb_rd_reg;
                        nf_next      = 1'b0;
                        seg_out_next = '0;
                    end
                    else if (flat)
                    begin
                        // zero-width segment: hold the start y
                        done_next    = 1'b1;
                        y_out_next   = ya_rd_reg;
                        nf_next      = 1'b0;
                        seg_out_next = pivot;
                    end
                    else
                    begin
                        dx_next     = xb_rd_reg - xa_rd_reg;
                        dxq_next    = xq_reg - xa_rd_reg;
                        dec_next    = (yb_rd_reg < ya_rd_reg);
                        dy_next     = (yb_rd_reg < ya_rd_reg) ? (ya_rd_reg - yb_rd_reg)
                                                              : (yb_rd_reg - ya_rd_reg);
                        base_y_next = ya_rd_reg;
                        seg_next    = pivot;
                    end
                end
                else
                begin
                    lo_next = lo_step;
                    hi_next = hi_step;
                end
            end
            pwl_pkg::BK_TAIL_CMP:
            begin
                done_next = 1'b1;
                if (xq_reg >= xb_rd_reg)
                begin
                    y_out_next   = yb_rd_reg;
                    nf_next      = 1'b0;
                    seg_out_next = len_m1_reg;
                end
                else
                begin
                    y_out_next   = '0;
                    nf_next      = 1'b1;
                    seg_out_next = '0;
                end
            end
            pwl_pkg::BK_MUL:
            begin
                div_start = 1'b1;
            end
            pwl_pkg::BK_DIV:
            begin
                if (div_done)
                begin
                    done_next    = 1'b1;
                    y_out_next   = interp_y;
                    nf_next      = 1'b0;
                    seg_out_next = seg_reg;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pwl_pkg::BK_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        len_m1_reg  <= len_m1_next;
        xq_reg      <= xq_next;
        dx_reg      <= dx_next;
        dxq_reg     <= dxq_next;
        dy_reg      <= dy_next;
        base_y_reg  <= base_y_next;
        dec_reg     <= dec_next;
        seg_reg     <= seg_next;
        y_out_reg   <= y_out_next;
        nf_reg      <= nf_next;
        seg_out_reg <= seg_out_next;
    end

    assign done      = done_reg;
    assign y_out     = y_out_reg;
    assign not_found = nf_reg;
    assign segment   = seg_out_reg;

endmodule

`default_nettype wire

/* sv/pwl_checker.sv */
// ----------------------------------------------------------------------------
// pwl_checker
// Port-level checks of the curve evaluator: results only answer accepted
// evaluate words, the number in flight stays bounded, and a miss reads zero.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pwl_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire logic                          opcode,
    input  wire logic                          done,
    input  wire logic [pwl_pkg::VAL_W-1:0]     y_out,
    input  wire logic                          not_found,
    input  wire logic [pwl_pkg::IDX_W-1:0]     segment
);

    logic [2:0] evals_reg, evals_next;
    logic       eval_in;

    assign eval_in = start && !busy && (opcode == pwl_pkg::OP_EVAL);

    // Track evaluate words without a result yet
    always_comb
    begin
        evals_next = evals_reg;
        if (eval_in && !done)
        begin
            evals_next = evals_reg + 1'b1;
        end
        else if (done && !eval_in)
        begin
            evals_next = evals_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evals_reg <= '0;
        end
        else
        begin
            evals_reg <= evals_next;
        end
    end

    `PWL_ASSERT_IMP(a_done_has_eval, done, evals_reg != 3'd0)
    `PWL_ASSERT_ALWAYS(a_evals_bounded, evals_reg <= 3'd3)
    `PWL_ASSERT_IMP(a_miss_reads_zero, done && not_found, (y_out == '0) && (segment == '0))

endmodule

bind piecewise_linear_curve_eval_top pwl_checker u_pwl_checker (.*);

`default_nettype wire
